// ===== hdl/tea_block_cipher_ecb_cbc_core_assert.svh =====
// assertion macros shared by the tea checker
`ifndef TEA_BLOCK_CIPHER_ECB_CBC_CORE_ASSERT_SVH
`define TEA_BLOCK_CIPHER_ECB_CBC_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define TEA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet in reset
`define TEA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tea_pkg.sv =====
// shared types, constants and round function of the tea cipher core
package tea_pkg;

	localparam logic [31:0] TEA_DELTA   = 32'h9e3779b9;
	localparam int          TEA_ROUNDS  = 32;
	localparam int          TEA_QDEPTH  = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_KEY0      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_VEC  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MOD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd6;

	typedef struct packed {
		logic        restart_chain;
		logic [31:0] text_high;
		logic [31:0] text_low;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result_high;
		logic [31:0] result_low;
	} out_item_t;

	typedef struct packed {
		logic [31:0] key_word0;
		logic [31:0] key_word1;
		logic [31:0] key_word2;
		logic [31:0] key_word3;
		logic [63:0] init_vector;
		logic        chain_mode;
		logic        direction;
	} cfg_t;

	// head of the queue between front and engine
	typedef struct packed {
		logic     valid;
		in_item_t entry;
	} q_head_t;

	function automatic logic [31:0] tea_mix(input logic [31:0] x, input logic [31:0] s,
		input logic [31:0] ka, input logic [31:0] kb);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		a = x + s;
		b = (x << 4) + ka;
		c = (x >> 5) + kb;
		return a ^ b ^ c;
	endfunction

endpackage

// ===== hdl/tea_block_cipher_ecb_cbc_core.sv =====
// top level of the tea block cipher core, ecb and cbc
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  blk     | in        | blk_valid/blk_ready | text_low, text_high, restart_chain
//  res     | out       | res_valid/res_ready | result_low, result_high
//  cfg     | in        | cfg_we              | cfg_index, cfg_wdata
//
// each item runs ROUNDS tea cycles in the round engine, one tea cycle per clock;
// the last one waits for a free output register; items follow back to back, queued
// in front of the engine, and a finished item sits in the output register
// reset clears the config registers, the chaining value, the queue and the engine
// a stalled output holds the engine in its last round; the queue keeps taking
// items until its QUEUE_DEPTH entries are full
module tea_block_cipher_ecb_cbc_core import tea_pkg::*; #(
	parameter int ROUNDS      = TEA_ROUNDS,
	parameter int QUEUE_DEPTH = TEA_QDEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  blk_valid,
	output logic                  blk_ready,
	input  in_item_t              blk_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output out_item_t             res_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	q_head_t head;
	logic    pop;

	// config registers, writes outside the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY0:      cfg_q.key_word0   <= cfg_wdata[31:0];
				REG_KEY1:      cfg_q.key_word1   <= cfg_wdata[31:0];
				REG_KEY2:      cfg_q.key_word2   <= cfg_wdata[31:0];
				REG_KEY3:      cfg_q.key_word3   <= cfg_wdata[31:0];
				REG_INIT_VEC:  cfg_q.init_vector <= cfg_wdata;
				REG_CHAIN_MOD: cfg_q.chain_mode  <= cfg_wdata[0];
				REG_DIRECTION: cfg_q.direction   <= cfg_wdata[0];
				default:       cfg_q             <= cfg_q;
			endcase
		end
	end

	// front: takes items, drops restart in ecb, queues them
	tea_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.blk_valid(blk_valid),
		.blk_ready(blk_ready),
		.blk_data (blk_data),
		.head     (head),
		.pop      (pop)
	);

	// back: runs the rounds, keeps the chaining value, holds the result
	tea_engine #(
		.ROUNDS(ROUNDS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.pop      (pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

endmodule

// ===== hdl/tea_front.sv =====
// input side: takes items, tags them and queues them for the engine
module tea_front import tea_pkg::*; #(
	parameter int QUEUE_DEPTH = TEA_QDEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     blk_valid,
	output logic     blk_ready,
	input  in_item_t blk_data,
	output q_head_t  head,
	input  logic     pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	in_item_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	in_item_t         marked_item;

	assign blk_ready = (count_q != CNT_FULL);
	assign push      = blk_valid && blk_ready;

	// restart only means something when chaining
	always_comb begin
		marked_item               = blk_data;
		marked_item.restart_chain = blk_data.restart_chain & cfg.chain_mode;
	end

	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= marked_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/tea_engine.sv =====
// back side: iterative tea rounds, cbc chaining and output register
module tea_engine import tea_pkg::*; #(
	parameter int ROUNDS = TEA_ROUNDS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  q_head_t   head,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_data
);

	localparam int CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROUNDS - 1);
	localparam logic [63:0] SUM_DEC_W = 64'(TEA_DELTA) * 64'(ROUNDS);
	localparam logic [31:0] SUM_DEC   = SUM_DEC_W[31:0];

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      v0_q;
	logic [31:0]      v1_q;
	logic [31:0]      sum_q;
	logic [63:0]      cv_q;
	logic [63:0]      chain_q;
	logic             res_valid_q;
	out_item_t        res_data_q;

	logic [31:0] e0, e1, d0, d1, r0, r1;
	logic        cbc, dec, out_free, fin, step;
	logic [63:0] blk_out, chain_fwd, cv_start, text, start_v;

	assign cbc = cfg.chain_mode;
	assign dec = cfg.direction;

	// one full cycle (two half-rounds) per clock, the last one held while the output is stalled
	always_comb begin
		e0 = v0_q + tea_mix(v1_q, sum_q, cfg.key_word0, cfg.key_word1);
		e1 = v1_q + tea_mix(e0, sum_q, cfg.key_word2, cfg.key_word3);
		d1 = v1_q - tea_mix(v0_q, sum_q, cfg.key_word2, cfg.key_word3);
		d0 = v0_q - tea_mix(d1, sum_q, cfg.key_word0, cfg.key_word1);
		r0 = dec ? d0 : e0;
		r1 = dec ? d1 : e1;
	end

	assign out_free = !res_valid_q || res_ready;
	assign fin      = busy_q && (cnt_q == CNT_LAST) && out_free;
	assign step     = busy_q && (cnt_q != CNT_LAST);
	assign pop      = head.valid && (!busy_q || fin);

	assign blk_out  = {r1, r0} ^ ((cbc && dec) ? cv_q : 64'd0);

	// forward a just-finished ciphertext to a block starting in the same cycle
	assign chain_fwd = (fin && cbc && !dec) ? {r1, r0} : chain_q;
	assign cv_start  = head.entry.restart_chain ? cfg.init_vector : chain_fwd;
	assign text      = {head.entry.text_high, head.entry.text_low};
	assign start_v   = (cbc && !dec) ? (text ^ cv_start) : text;

	always_ff @(posedge clk) begin
		if (pop) begin
			v0_q  <= start_v[31:0];
			v1_q  <= start_v[63:32];
			sum_q <= dec ? SUM_DEC : TEA_DELTA;
			cv_q  <= cv_start;
		end else if (step) begin
			v0_q  <= r0;
			v1_q  <= r1;
			sum_q <= dec ? (sum_q - TEA_DELTA) : (sum_q + TEA_DELTA);
		end
		if (fin) begin
			res_data_q.result_low  <= blk_out[31:0];
			res_data_q.result_high <= blk_out[63:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			chain_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (step) begin
				cnt_q <= cnt_q + 1'b1;
			end

			if (pop && cbc && dec) begin
				chain_q <= text;
			end else if (fin && cbc && !dec) begin
				chain_q <= {r1, r0};
			end

			if (fin) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

// ===== hdl/tea_chk.sv =====
// port-level checker for the tea cipher core and its bind
`include "tea_block_cipher_ecb_cbc_core_assert.svh"

module tea_chk import tea_pkg::*; #(
	parameter int QUEUE_DEPTH = TEA_QDEPTH
) (
	input logic      clk,
	input logic      arst_n,
	input logic      blk_valid,
	input logic      blk_ready,
	input logic      res_valid,
	input logic      res_ready,
	input out_item_t res_data
);

	localparam int OUT_W = $clog2(QUEUE_DEPTH + 4);
	localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'(QUEUE_DEPTH + 2);

	logic [OUT_W-1:0] outstanding_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = blk_valid && blk_ready;
	assign out_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + OUT_W'(in_acc) - OUT_W'(out_acc);
		end
	end

	`TEA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result changed while stalled")
	`TEA_ASSERT_NOW(a_no_phantom, res_valid, outstanding_q != '0, "result with no item outstanding")
	`TEA_ASSERT_NEXT(a_no_early, outstanding_q == '0, !res_valid, "result too soon after idle")
	`TEA_ASSERT_NOW(a_bound, 1'b1, outstanding_q <= OUT_MAX, "more items held than storage allows")

endmodule

bind tea_block_cipher_ecb_cbc_core tea_chk #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.blk_valid(blk_valid),
	.blk_ready(blk_ready),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res_data (res_data)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the tea block cipher core in ecb and cbc modes
`timescale 1ns / 1ps

module testbench;
	import tea_pkg::*;

	// the only index the config port can carry that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	// watchdog limit on the whole run
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_PHASES = 16;
	localparam int BLOCKS_PER_PHASE = 53;
	// mismatch lines printed before going quiet, all are still counted
	localparam int PRINT_CAP = 100;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  blk_valid = 1'b0;
	logic                  blk_ready;
	in_item_t              blk_data = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	out_item_t             res_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// shadow copy of the register file and the chaining state
	logic [31:0] key_words [4];
	logic [63:0] chain_iv;
	logic        cbc_on;
	logic        decrypt_on;
	logic [63:0] chain_link;

	in_item_t  pending_blocks [$];
	out_item_t expected_results [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int blocks_sent = 0;
	int results_checked = 0;
	int settings_count = 0;
	int cycle_count = 0;

	tea_block_cipher_ecb_cbc_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_ready (blk_ready),
		.blk_data  (blk_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// cipher prediction
	// ---------------------------------------------------------------

	// feistel mixing term of one half-round
	function automatic logic [31:0] feistel_term(logic [31:0] x, logic [31:0] s,
		logic [31:0] ka, logic [31:0] kb);
		logic [31:0] sum_part;
		logic [31:0] left_part;
		logic [31:0] right_part;
		sum_part   = x + s;
		left_part  = (x << 4) + ka;
		right_part = (x >> 5) + kb;
		return sum_part ^ left_part ^ right_part;
	endfunction

	// low word in bits 31:0, as on the ports
	function automatic logic [63:0] tea_encipher(logic [63:0] blk);
		logic [31:0] v0;
		logic [31:0] v1;
		logic [31:0] s;
		int r;
		v0 = blk[31:0];
		v1 = blk[63:32];
		s = '0;
		for (r = 0; r < TEA_ROUNDS; r++) begin
			s  = s + TEA_DELTA;
			v0 = v0 + feistel_term(v1, s, key_words[0], key_words[1]);
			v1 = v1 + feistel_term(v0, s, key_words[2], key_words[3]);
		end
		return {v1, v0};
	endfunction

	function automatic logic [63:0] tea_decipher(logic [63:0] blk);
		logic [31:0] v0;
		logic [31:0] v1;
		logic [31:0] s;
		int r;
		v0 = blk[31:0];
		v1 = blk[63:32];
		// sum after the last round, wraps modulo 2^32
		s = TEA_DELTA * TEA_ROUNDS;
		for (r = 0; r < TEA_ROUNDS; r++) begin
			v1 = v1 - feistel_term(v0, s, key_words[2], key_words[3]);
			v0 = v0 - feistel_term(v1, s, key_words[0], key_words[1]);
			s  = s - TEA_DELTA;
		end
		return {v1, v0};
	endfunction

	// works out the result of one block and moves the chain on
	function automatic out_item_t predict_block(in_item_t item);
		logic [63:0] blk;
		logic [63:0] link;
		logic [63:0] res;
		out_item_t   outcome;
		blk = {item.text_high, item.text_low};
		if (!cbc_on) begin
			// ecb: restart flag has no effect and the chain is left alone
			res = decrypt_on ? tea_decipher(blk) : tea_encipher(blk);
		end else begin
			link = item.restart_chain ? chain_iv : chain_link;
			if (!decrypt_on) begin
				res = tea_encipher(blk ^ link);
				chain_link = res;
			end else begin
				// decrypt chains the incoming ciphertext
				chain_link = blk;
				res = tea_decipher(blk) ^ link;
			end
		end
		outcome.result_low  = res[31:0];
		outcome.result_high = res[63:32];
		return outcome;
	endfunction

	task automatic note_mismatch(string msg);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// ---------------------------------------------------------------
	// driver: feeds pending items, valid held until accepted
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			blk_valid <= 1'b0;
		end else begin
			// accepted item: expectation is taken with the current settings
			if (blk_valid && blk_ready) begin
				expected_results.push_back(predict_block(blk_data));
				blocks_sent++;
			end
			// slot is free once nothing is waiting or the item just went in
			if (!blk_valid || blk_ready) begin
				if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					blk_valid <= 1'b1;
					blk_data  <= pending_blocks.pop_front();
				end else begin
					blk_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: checks each result against the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					note_mismatch($sformatf("result %h with nothing expected", res_data));
				end else begin
					want = expected_results.pop_front();
					if (res_data.result_low !== want.result_low)
						note_mismatch($sformatf("result_low %h, expected %h",
							res_data.result_low, want.result_low));
					if (res_data.result_high !== want.result_high)
						note_mismatch($sformatf("result_high %h, expected %h",
							res_data.result_high, want.result_high));
					results_checked++;
				end
			end
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_results.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// one register write, shadow copy follows with the width the register keeps
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_KEY0:      key_words[0] = value[31:0];
			REG_KEY1:      key_words[1] = value[31:0];
			REG_KEY2:      key_words[2] = value[31:0];
			REG_KEY3:      key_words[3] = value[31:0];
			REG_INIT_VEC:  chain_iv = value;
			REG_CHAIN_MOD: cbc_on = value[0];
			REG_DIRECTION: decrypt_on = value[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// waits until every item is in and every result is out, checked on the
	// falling edge so that the driver's updates have settled
	task automatic settle();
		do
			@(negedge clk);
		while (pending_blocks.size() != 0 || blk_valid || expected_results.size() != 0);
		settings_count++;
	endtask

	task automatic queue_block(logic [31:0] lo, logic [31:0] hi, logic restart);
		in_item_t item;
		item.text_low      = lo;
		item.text_high     = hi;
		item.restart_chain = restart;
		pending_blocks.push_back(item);
	endtask

	// words biased towards the extremes
	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_settings(logic cbc, logic dec);
		// upper half of the data is junk that the key registers must drop
		write_reg(REG_KEY0, {$urandom, pick_word()});
		write_reg(REG_KEY1, {$urandom, pick_word()});
		write_reg(REG_KEY2, {$urandom, pick_word()});
		write_reg(REG_KEY3, {$urandom, pick_word()});
		if ($urandom_range(3) != 0)
			write_reg(REG_INIT_VEC, {pick_word(), pick_word()});
		write_reg(REG_CHAIN_MOD, {$urandom, 31'($urandom), cbc});
		write_reg(REG_DIRECTION, {$urandom, 31'($urandom), dec});
		if ($urandom_range(7) == 0)
			write_reg(REG_UNUSED, {$urandom, $urandom});
	endtask

	// chained runs mostly continue the chain, with the odd restart
	task automatic queue_random_blocks(int count, logic chained);
		int i;
		logic restart;
		for (i = 0; i < count; i++) begin
			if (chained)
				restart = (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(9) == 0);
			else
				restart = 1'($urandom_range(1));
			queue_block(pick_word(), pick_word(), restart);
		end
	endtask

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin : stimulus
		int p;
		int op;
		int idle_mode;
		key_words[0] = '0;
		key_words[1] = '0;
		key_words[2] = '0;
		key_words[3] = '0;
		chain_iv   = '0;
		cbc_on     = 1'b0;
		decrypt_on = 1'b0;
		chain_link = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: zero key, ecb encrypt, restart flag ignored
		queue_block('0, '0, 1'b0);
		queue_block('1, '1, 1'b1);
		queue_block(32'ha5a5a5a5, 32'h5a5a5a5a, 1'b0);
		settle();

		// cbc straight after reset chains from the zero reset value,
		// the all-ones write keeps only bit 0
		write_reg(REG_CHAIN_MOD, '1);
		queue_block(32'h00000001, 32'h80000000, 1'b0);
		queue_block('1, '0, 1'b0);
		queue_block(32'h12345678, 32'h9abcdef0, 1'b1);
		settle();

		// extreme keys, junk in the upper half of each key write
		write_reg(REG_KEY0, 64'hdeadbeef_ffffffff);
		write_reg(REG_KEY1, 64'hffffffff_00000000);
		write_reg(REG_KEY2, 64'h00000000_80000000);
		write_reg(REG_KEY3, 64'h12345678_7fffffff);
		write_reg(REG_INIT_VEC, '1);
		queue_block('0, '0, 1'b1);
		queue_block('0, '0, 1'b0);
		queue_block('1, '1, 1'b0);
		settle();

		// a new init vector leaves the running chain alone until a restart
		write_reg(REG_INIT_VEC, 64'h0f0f0f0f_f0f0f0f0);
		queue_block(32'hcafef00d, 32'h0badc0de, 1'b0);
		queue_block(32'hcafef00d, 32'h0badc0de, 1'b1);
		settle();

		// cbc decrypt
		write_reg(REG_DIRECTION, 64'h1);
		queue_block('1, '0, 1'b1);
		queue_block('0, '1, 1'b0);
		queue_block(32'h55555555, 32'haaaaaaaa, 1'b0);
		settle();

		// ecb decrypt: only bit 0 of the mode write is kept, so this is ecb
		write_reg(REG_CHAIN_MOD, 64'hffffffff_fffffffe);
		queue_block('1, '1, 1'b1);
		queue_block('0, '0, 1'b0);
		settle();

		// ecb encrypt, then a write to the unused index that must change nothing
		write_reg(REG_DIRECTION, 64'h0);
		queue_block(32'h80000000, 32'h00000001, 1'b0);
		queue_block(32'h7fffffff, 32'hfffffffe, 1'b1);
		settle();
		write_reg(REG_UNUSED, '1);
		queue_block(32'h80000000, 32'h00000001, 1'b0);
		settle();

		// random part: every mode under every idling pattern
		for (p = 0; p < RANDOM_PHASES; p++) begin
			idle_mode = p % 4;
			op = (p + p / 4) % 4;
			case (idle_mode)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 68;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 68;
				end
				default: begin
					send_idle_pct = 38;
					recv_stall_pct = 38;
				end
			endcase
			random_settings(op[1], op[0]);
			queue_random_blocks(BLOCKS_PER_PHASE, op[1]);
			settle();
		end

		// catch any stray result arriving late
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (TEA_ROUNDS + 16) @(posedge clk);
		if (expected_results.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		$display("covered ecb and cbc, encrypt and decrypt: %0d blocks in, %0d results checked",
			blocks_sent, results_checked);
		$display("over %0d register settings with idling on both channels, %0d mismatches",
			settings_count, error_count);
		if (error_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tea_pkg.sv
hdl/tea_front.sv
hdl/tea_engine.sv
hdl/tea_block_cipher_ecb_cbc_core.sv
hdl/tea_chk.sv
tb/testbench.sv
